// File: src/dof_pkg.sv
package dof_pkg;

  // field widths fixed by the packet format
  localparam int IDX_W  = 11;
  localparam int SUM_W  = IDX_W + 1;
  localparam int BYTE_W = 8;

  localparam int OPTIONS_MAX_DEF = 1024;

  localparam logic [IDX_W-1:0] FILE_AREA_LEN  = IDX_W'(128);
  localparam logic [IDX_W-1:0] SNAME_AREA_LEN = IDX_W'(64);

  // option codes with special meaning
  localparam logic [BYTE_W-1:0] CODE_PAD      = 8'd0;
  localparam logic [BYTE_W-1:0] CODE_OVERLOAD = 8'd52;
  localparam logic [BYTE_W-1:0] CODE_END      = 8'd255;

  // parse phases
  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_SCAN      = 3'd1;
  localparam logic [2:0] PH_LEN_MATCH = 3'd2;
  localparam logic [2:0] PH_LEN_OVER  = 3'd3;
  localparam logic [2:0] PH_LEN_OTHER = 3'd4;
  localparam logic [2:0] PH_OVER_VAL  = 3'd5;
  localparam logic [2:0] PH_DRAIN     = 3'd6;

  // verdicts
  localparam logic [1:0] ST_FOUND     = 2'd0;
  localparam logic [1:0] ST_ABSENT    = 2'd1;
  localparam logic [1:0] ST_MALFORMED = 2'd2;

  // areas
  localparam logic [1:0] AREA_OPTIONS = 2'd0;
  localparam logic [1:0] AREA_FILE    = 2'd1;
  localparam logic [1:0] AREA_SNAME   = 2'd2;

endpackage

// File: src/dhcp_option_finder_unit.sv
// dhcp option finder
// input channel: data_valid / data_stall with data_byte, first, options_length
// and option_code. one byte of the option areas per transfer: the options
// field (first set on its first byte, length and searched code sampled there),
// then the 128-byte file field, then the 64-byte sname field
// output channel: result_valid / result_stall with status, area, value_offset
// and value_length; at most one transfer per packet carrying found, absent or
// malformed. bytes after the verdict are ignored until the next first byte
// the verdict is registered and appears in the cycle after its deciding byte
// throughput: one byte per cycle unless data_stall is high; all parse state
// is set by counter adds and compares on the accepted byte and state registers
// stalls: data_stall is raised only while a verdict sits in the result register
// and result_stall is high, so bytes keep flowing while no verdict waits
// reset: rst (synchronous) empties the result register and returns the parser
// to idle, where it waits for a byte with first set
module dhcp_option_finder_unit
  import dof_pkg::*;
#(
  parameter int OPTIONS_MAX = OPTIONS_MAX_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              data_valid,
  output logic              data_stall,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              first,
  input  logic [IDX_W-1:0]  options_length,
  input  logic [BYTE_W-1:0] option_code,
  output logic              result_valid,
  input  logic              result_stall,
  output logic [1:0]        status,
  output logic [1:0]        area,
  output logic [IDX_W-1:0]  value_offset,
  output logic [BYTE_W-1:0] value_length
);

  localparam logic [SUM_W+1:0] OPT_MAX_W = (SUM_W+2)'(OPTIONS_MAX);

  // parse state
  logic [BYTE_W-1:0] search_code, search_code_next;
  logic [IDX_W-1:0]  area_length, area_length_next;
  logic [1:0]        area_select, area_select_next;
  logic [IDX_W-1:0]  byte_index, byte_index_next;
  logic [IDX_W-1:0]  next_option_at, next_option_at_next;
  logic [2:0]        parse_phase, parse_phase_next;
  logic [1:0]        overload_flags, overload_flags_next;

  // verdict of the current byte
  logic              emit;
  logic [1:0]        emit_status;
  logic [1:0]        emit_area;
  logic [IDX_W-1:0]  emit_offset;
  logic [BYTE_W-1:0] emit_length;

  logic              accept;
  logic [SUM_W-1:0]  idx_plus1;
  logic [SUM_W-1:0]  idx_plus_b;
  logic [SUM_W-1:0]  idx_skip;
  logic [SUM_W-1:0]  alen_w;
  logic              last_pos;
  logic              cont_ok;

  assign data_stall = result_valid && result_stall;
  assign accept     = data_valid && !data_stall;

  always_comb begin
    // a first byte restarts the walk in any phase
    if (first) begin
      search_code_next    = option_code;
      area_length_next    = ({3'b000, options_length} > OPT_MAX_W) ?
                            OPT_MAX_W[IDX_W-1:0] : options_length;
      area_select_next    = AREA_OPTIONS;
      byte_index_next     = '0;
      next_option_at_next = '0;
      overload_flags_next = '0;
      parse_phase_next    = PH_SCAN;
    end else begin
      search_code_next    = search_code;
      area_length_next    = area_length;
      area_select_next    = area_select;
      byte_index_next     = byte_index;
      next_option_at_next = next_option_at;
      overload_flags_next = overload_flags;
      parse_phase_next    = parse_phase;
    end

    emit        = 1'b0;
    emit_status = ST_MALFORMED;
    emit_area   = AREA_OPTIONS;
    emit_offset = '0;
    emit_length = '0;

    idx_plus1  = {1'b0, byte_index_next} + SUM_W'(1);
    idx_plus_b = {1'b0, byte_index_next} + SUM_W'(data_byte);
    idx_skip   = idx_plus1 + SUM_W'(data_byte);
    alen_w     = {1'b0, area_length_next};
    last_pos   = idx_plus1 >= alen_w;
    cont_ok    = (area_select_next == AREA_OPTIONS && overload_flags_next[0]) ||
                 (area_select_next == AREA_FILE && overload_flags_next[1]);

    case (parse_phase_next)
      PH_SCAN: begin
        // inside a skipped value nothing happens
        if (byte_index_next >= next_option_at_next) begin
          if (byte_index_next >= area_length_next) begin
            emit = 1'b1;
          end else if (data_byte == search_code_next) begin
            if (last_pos) emit = 1'b1;
            else parse_phase_next = PH_LEN_MATCH;
          end else if (data_byte == CODE_PAD) begin
            if (last_pos) emit = 1'b1;
            else next_option_at_next = idx_plus1[IDX_W-1:0];
          end else if (data_byte == CODE_OVERLOAD) begin
            if (last_pos) emit = 1'b1;
            else parse_phase_next = PH_LEN_OVER;
          end else if (data_byte == CODE_END) begin
            if (cont_ok) begin
              parse_phase_next = PH_DRAIN;
            end else begin
              emit        = 1'b1;
              emit_status = ST_ABSENT;
            end
          end else begin
            if (last_pos) emit = 1'b1;
            else parse_phase_next = PH_LEN_OTHER;
          end
        end
      end
      PH_LEN_MATCH: begin
        emit = 1'b1;
        if (idx_plus_b < alen_w) begin
          emit_status = ST_FOUND;
          emit_area   = area_select_next;
          emit_offset = idx_plus1[IDX_W-1:0];
          emit_length = data_byte;
        end
      end
      PH_LEN_OVER, PH_LEN_OTHER: begin
        next_option_at_next = idx_skip[IDX_W-1:0];
        if (idx_skip >= alen_w) begin
          emit = 1'b1;
        end else if (parse_phase_next == PH_LEN_OVER && data_byte != CODE_PAD) begin
          parse_phase_next = PH_OVER_VAL;
        end else begin
          parse_phase_next = PH_SCAN;
        end
      end
      PH_OVER_VAL: begin
        overload_flags_next = data_byte[1:0];
        parse_phase_next    = PH_SCAN;
      end
      default: begin
      end
    endcase

    if (emit) begin
      parse_phase_next = PH_IDLE;
    end else if (parse_phase_next != PH_IDLE) begin
      byte_index_next = idx_plus1[IDX_W-1:0];
      // end of a drained area: move to the next one
      if (parse_phase_next == PH_DRAIN && idx_plus1 >= alen_w) begin
        area_select_next    = area_select_next + 2'd1;
        area_length_next    = (area_select_next == AREA_FILE) ?
                              FILE_AREA_LEN : SNAME_AREA_LEN;
        byte_index_next     = '0;
        next_option_at_next = '0;
        parse_phase_next    = PH_SCAN;
      end
    end
  end

  // parse state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      search_code    <= '0;
      area_length    <= '0;
      area_select    <= AREA_OPTIONS;
      byte_index     <= '0;
      next_option_at <= '0;
      parse_phase    <= PH_IDLE;
      overload_flags <= '0;
    end else if (accept) begin
      search_code    <= search_code_next;
      area_length    <= area_length_next;
      area_select    <= area_select_next;
      byte_index     <= byte_index_next;
      next_option_at <= next_option_at_next;
      parse_phase    <= parse_phase_next;
      overload_flags <= overload_flags_next;
    end
  end

  // result register, taken over by each new verdict
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept && emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      status       <= emit_status;
      area         <= emit_area;
      value_offset <= emit_offset;
      value_length <= emit_length;
    end
  end

  // a verdict always returns the parser to idle
  a_idle_after_verdict: assert property (@(posedge clk) disable iff (rst)
    accept && emit |=> parse_phase == PH_IDLE)
    else $error("parser not idle after verdict");

  // only a found verdict carries location fields
  a_clean_non_found: assert property (@(posedge clk) disable iff (rst)
    result_valid && status != ST_FOUND |->
      area == AREA_OPTIONS && value_offset == '0 && value_length == '0)
    else $error("location fields set on a non-found verdict");

  // the walk never goes past the sname area
  a_area_range: assert property (@(posedge clk) disable iff (rst)
    parse_phase != PH_IDLE |-> area_select != 2'd3)
    else $error("area select out of range");

  // a found value lies inside its area
  a_found_fits: assert property (@(posedge clk) disable iff (rst)
    accept && emit && emit_status == ST_FOUND |->
      ({1'b0, emit_offset} + SUM_W'(emit_length)) <= {1'b0, area_length_next})
    else $error("found value runs past its area");

endmodule

// File: tb/tb_dhcp_option_finder_unit.sv
module tb_dhcp_option_finder_unit;
  import dof_pkg::*;

  // watchdog: cycles with no transfer on either channel
  localparam int STUCK_LIMIT = 1000;
  // receiver hold-off used to fill the block
  localparam int HOLD_CYCLES = 60;

  // one verdict as it leaves the block
  typedef struct packed {
    logic [1:0]        st;
    logic [1:0]        ar;
    logic [IDX_W-1:0]  off;
    logic [BYTE_W-1:0] len;
  } verdict_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              data_valid = 1'b0;
  logic              data_stall;
  logic [BYTE_W-1:0] data_byte = '0;
  logic              first = 1'b0;
  logic [IDX_W-1:0]  options_length = '0;
  logic [BYTE_W-1:0] option_code = '0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  logic [1:0]        status;
  logic [1:0]        area;
  logic [IDX_W-1:0]  value_offset;
  logic [BYTE_W-1:0] value_length;

  dhcp_option_finder_unit dut (
    .clk            (clk),
    .rst            (rst),
    .data_valid     (data_valid),
    .data_stall     (data_stall),
    .data_byte      (data_byte),
    .first          (first),
    .options_length (options_length),
    .option_code    (option_code),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .status         (status),
    .area           (area),
    .value_offset   (value_offset),
    .value_length   (value_length)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // shadow of the option walk, advanced once per accepted byte
  logic [BYTE_W-1:0] walk_code  = '0;
  int                walk_len   = 0;
  logic [1:0]        walk_area  = AREA_OPTIONS;
  int                walk_pos   = 0;
  int                walk_next  = 0;
  logic [2:0]        walk_phase = PH_IDLE;
  logic [1:0]        walk_ovl   = '0;

  verdict_t          verdicts_due[$];
  logic [BYTE_W-1:0] pkt_q[$];

  // run bookkeeping
  int  mismatches = 0;
  int  live_bytes = 0;
  int  sent_bytes = 0;
  int  packets_started = 0;
  int  n_found = 0;
  int  n_absent = 0;
  int  n_malformed = 0;
  int  found_in_file = 0;
  int  found_in_sname = 0;
  int  in_stall_cycles = 0;
  int  stuck_cycles = 0;
  bit  gaps_on = 1'b0;
  bit  stall_on = 1'b0;
  bit  hold_req = 1'b0;
  int  long_holds = 0;

  // next state of the walk for one byte; returns 1 when the byte decides the verdict
  function automatic bit predict_verdict(input logic [BYTE_W-1:0] b, input logic fst,
                                         input logic [IDX_W-1:0] ol,
                                         input logic [BYTE_W-1:0] code,
                                         output verdict_t v);
    bit decided;
    bit last;
    decided = 1'b0;
    v = '0;
    v.st = ST_MALFORMED;
    if (fst) begin
      walk_code  = code;
      // over-long options field is clamped to OPTIONS_MAX_DEF
      walk_len   = (int'(ol) > OPTIONS_MAX_DEF) ? OPTIONS_MAX_DEF : int'(ol);
      walk_area  = AREA_OPTIONS;
      walk_pos   = 0;
      walk_next  = 0;
      walk_ovl   = '0;
      walk_phase = PH_SCAN;
    end else if (walk_phase == PH_IDLE) begin
      return 1'b0;
    end

    case (walk_phase)
      PH_SCAN: begin
        if (walk_pos >= walk_next) begin
          if (walk_pos >= walk_len) begin
            decided = 1'b1;
          end else begin
            // nothing but end fits on the last byte of an area
            last = (walk_pos + 1 >= walk_len);
            if (b == walk_code) begin
              if (last) decided = 1'b1;
              else walk_phase = PH_LEN_MATCH;
            end else if (b == CODE_PAD) begin
              if (last) decided = 1'b1;
              else walk_next = walk_pos + 1;
            end else if (b == CODE_OVERLOAD) begin
              if (last) decided = 1'b1;
              else walk_phase = PH_LEN_OVER;
            end else if (b == CODE_END) begin
              if ((walk_area == AREA_OPTIONS && walk_ovl[0]) ||
                  (walk_area == AREA_FILE && walk_ovl[1])) begin
                walk_phase = PH_DRAIN;
              end else begin
                decided = 1'b1;
                v.st = ST_ABSENT;
              end
            end else begin
              if (last) decided = 1'b1;
              else walk_phase = PH_LEN_OTHER;
            end
          end
        end
      end
      PH_LEN_MATCH: begin
        decided = 1'b1;
        if (walk_pos + int'(b) < walk_len) begin
          v.st  = ST_FOUND;
          v.ar  = walk_area;
          v.off = IDX_W'(walk_pos + 1);
          v.len = b;
        end
      end
      PH_LEN_OVER, PH_LEN_OTHER: begin
        walk_next = walk_pos + 1 + int'(b);
        if (walk_next >= walk_len) decided = 1'b1;
        else if (walk_phase == PH_LEN_OVER && b != 8'd0) walk_phase = PH_OVER_VAL;
        else walk_phase = PH_SCAN;
      end
      PH_OVER_VAL: begin
        walk_ovl   = b[1:0];
        walk_phase = PH_SCAN;
      end
      default: ;
    endcase

    if (decided) walk_phase = PH_IDLE;
    if (walk_phase != PH_IDLE) begin
      walk_pos++;
      // drained to the end of the area: carry on in the next one
      if (walk_phase == PH_DRAIN && walk_pos >= walk_len) begin
        walk_area  = walk_area + 2'd1;
        walk_len   = (walk_area == AREA_FILE) ? int'(FILE_AREA_LEN) : int'(SNAME_AREA_LEN);
        walk_pos   = 0;
        walk_next  = 0;
        walk_phase = PH_SCAN;
      end
    end
    return decided;
  endfunction

  // one byte transfer on the input channel, with an optional idle burst before it
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic fst,
                           input logic [IDX_W-1:0] ol, input logic [BYTE_W-1:0] code);
    verdict_t v;
    bit live;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      data_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    data_valid     <= 1'b1;
    data_byte      <= b;
    first          <= fst;
    options_length <= ol;
    option_code    <= code;
    do @(posedge clk); while (data_stall);
    sent_bytes++;
    // bytes swallowed while idle do not count as parsed
    live = fst || (walk_phase != PH_IDLE);
    if (live) live_bytes++;
    if (fst) packets_started++;
    if (predict_verdict(b, fst, ol, code, v)) verdicts_due.push_back(v);
    @(negedge clk);
  endtask

  // send the bytes collected in pkt_q as one packet, first byte carrying the header
  task automatic send_packet(input logic [IDX_W-1:0] ol, input logic [BYTE_W-1:0] code);
    int i;
    for (i = 0; i < pkt_q.size(); i++) begin
      if (i == 0) send_byte(pkt_q[i], 1'b1, ol, code);
      else send_byte(pkt_q[i], 1'b0, IDX_W'($urandom), BYTE_W'($urandom));
    end
    pkt_q.delete();
  endtask

  // append one area of len bytes with random options, mostly well-formed and closed by end
  task automatic add_area(input int len, input logic [BYTE_W-1:0] code, input int match_pct,
                          inout logic [1:0] flags);
    int pos;
    int room;
    int l;
    int r;
    int k;
    logic [BYTE_W-1:0] c;
    bit ended;
    pos = 0;
    ended = 1'b0;
    while (!ended && pos < len - 1) begin
      room = len - pos;
      r = $urandom_range(0, 99);
      if (r < 12) begin
        pkt_q.push_back(CODE_PAD);
        pos++;
      end else if (r < 22 && room >= 4) begin
        c = BYTE_W'($urandom);
        pkt_q.push_back(CODE_OVERLOAD);
        pkt_q.push_back(8'd1);
        pkt_q.push_back(c);
        flags = c[1:0];
        pos += 3;
      end else if (r < 22 + match_pct) begin
        // searched option, now and then one that overruns the area
        l = ($urandom_range(0, 9) == 0) ? room - 1 : $urandom_range(0, room - 2);
        pkt_q.push_back(code);
        pkt_q.push_back(BYTE_W'(l));
        for (k = 0; k < l; k++) pkt_q.push_back(BYTE_W'($urandom));
        pos += 2 + l;
      end else if (r < 30 + match_pct || room < 3) begin
        pkt_q.push_back(CODE_END);
        pos++;
        ended = 1'b1;
      end else begin
        do c = BYTE_W'($urandom);
        while (c == CODE_PAD || c == CODE_OVERLOAD || c == CODE_END || c == code);
        l = $urandom_range(0, (room - 3 < 16) ? room - 3 : 16);
        pkt_q.push_back(c);
        pkt_q.push_back(BYTE_W'(l));
        for (k = 0; k < l; k++) pkt_q.push_back(BYTE_W'($urandom));
        pos += 2 + l;
      end
    end
    if (!ended && pos == len - 1) begin
      pkt_q.push_back(($urandom_range(0, 9) == 0) ? BYTE_W'($urandom) : CODE_END);
      pos++;
    end
    // rest of the area after end is skipped by the block
    while (pos < len) begin
      pkt_q.push_back(BYTE_W'($urandom));
      pos++;
    end
  endtask

  // one random packet: plain, overloaded, long, or broken with stray bytes
  task automatic random_packet();
    int r;
    int L;
    int n;
    logic [BYTE_W-1:0] code;
    logic [BYTE_W-1:0] v;
    logic [IDX_W-1:0] ol;
    logic [1:0] flags;
    r = $urandom_range(0, 99);
    case ($urandom_range(0, 24))
      0, 1:    code = CODE_PAD;
      2:       code = CODE_END;
      3:       code = CODE_OVERLOAD;
      default: code = BYTE_W'($urandom_range(1, 254));
    endcase
    flags = '0;
    if (r < 50) begin
      L = $urandom_range(1, 40);
      ol = IDX_W'(L);
      if ($urandom_range(0, 9) == 0) ol = IDX_W'($urandom_range(OPTIONS_MAX_DEF + 1, 2047));
      add_area(L, code, 12, flags);
      // cut short now and then, so the next packet restarts mid-walk
      if ($urandom_range(0, 9) == 0) pkt_q = pkt_q[0:$urandom_range(0, pkt_q.size() - 1)];
      send_packet(ol, code);
    end else if (r < 70) begin
      // overload up front, continuing into file and perhaps sname
      L = $urandom_range(6, 30);
      v = BYTE_W'($urandom);
      v[0] = 1'b1;
      pkt_q.push_back(CODE_OVERLOAD);
      pkt_q.push_back(8'd1);
      pkt_q.push_back(v);
      flags = v[1:0];
      add_area(L - 3, code, 6, flags);
      if (flags[0]) add_area(int'(FILE_AREA_LEN), code, 4, flags);
      if (flags[1]) add_area(int'(SNAME_AREA_LEN), code, 8, flags);
      send_packet(IDX_W'(L), code);
    end else if (r < 80) begin
      L = $urandom_range(41, 300);
      add_area(L, code, 3, flags);
      send_packet(IDX_W'(L), code);
    end else begin
      // stray bytes while idle, then a short packet of random content
      repeat ($urandom_range(0, 3))
        send_byte(BYTE_W'($urandom), 1'b0, IDX_W'($urandom), BYTE_W'($urandom));
      n = $urandom_range(1, 12);
      repeat (n) pkt_q.push_back(BYTE_W'($urandom));
      send_packet(IDX_W'($urandom_range(0, 16)), BYTE_W'($urandom));
    end
  endtask

  // receiver: random stall bursts, plus a long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = HOLD_CYCLES;
        long_holds++;
      end else if (stall_left == 0 && stall_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 10);
      end
      if (stall_left > 0) begin
        result_stall <= 1'b1;
        stall_left--;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  // result checker and stall bookkeeping
  always @(posedge clk) begin
    verdict_t want;
    if (!rst) begin
      if ((data_valid && !data_stall) || (result_valid && !result_stall)) stuck_cycles <= 0;
      else stuck_cycles <= stuck_cycles + 1;
      if (data_valid && data_stall) in_stall_cycles++;
      if (result_valid && !result_stall) begin
        if (verdicts_due.size() == 0) begin
          $display("%0t: verdict with none expected, actual status %0d area %0d offset %0d length %0d",
                   $time, status, area, value_offset, value_length);
          mismatches++;
        end else begin
          want = verdicts_due.pop_front();
          check_field("status", want.st, status);
          check_field("area", want.ar, area);
          check_field("value_offset", want.off, value_offset);
          check_field("value_length", want.len, value_length);
          if (want.st == ST_FOUND) begin
            n_found++;
            if (want.ar == AREA_FILE) found_in_file++;
            if (want.ar == AREA_SNAME) found_in_sname++;
          end else if (want.st == ST_ABSENT) begin
            n_absent++;
          end else begin
            n_malformed++;
          end
        end
      end
    end
  end

  // watchdog
  initial begin
    while (stuck_cycles < STUCK_LIMIT) @(posedge clk);
    $display("%0t: no transfer for %0d cycles, %0d verdicts outstanding",
             $time, STUCK_LIMIT, verdicts_due.size());
    $display("dhcp_option_finder_unit verification failed");
    $finish;
  end

  // bytes with first low before any packet are swallowed
  task automatic test_idle_bytes();
    send_byte(8'hA5, 1'b0, 11'h5AA, 8'h5A);
    send_byte(8'h5A, 1'b0, 11'h2D5, 8'hA5);
  endtask

  // empty options field, clamped over-long length, searched code at the extremes
  task automatic test_field_extremes();
    pkt_q = '{8'h01};
    send_packet(11'd0, 8'h01);
    pkt_q = '{8'h01, 8'h02};
    send_packet(11'h7FF, 8'h01);
    pkt_q = '{CODE_END};
    send_packet(11'd1024, 8'hFE);
  endtask

  // last byte of an area, option overrun, searched value overrun and exact fit
  task automatic test_area_edges();
    pkt_q = '{CODE_PAD, CODE_PAD, CODE_PAD};
    send_packet(11'd3, 8'd9);
    pkt_q = '{CODE_PAD, CODE_PAD, 8'd9};
    send_packet(11'd3, 8'd9);
    pkt_q = '{8'd5, 8'd3};
    send_packet(11'd4, 8'd9);
    pkt_q = '{8'd6, 8'd3};
    send_packet(11'd5, 8'd6);
    pkt_q = '{8'd6, 8'd3};
    send_packet(11'd4, 8'd6);
  endtask

  // pad and end searched as ordinary codes
  task automatic test_pad_end_search();
    pkt_q = '{CODE_PAD, 8'd1};
    send_packet(11'd4, CODE_PAD);
    pkt_q = '{CODE_END, 8'd0};
    send_packet(11'd4, CODE_END);
  endtask

  // overload of length zero keeps the flags clear, so end stops the search
  task automatic test_overload_zero_len();
    pkt_q = '{CODE_OVERLOAD, 8'd0, CODE_END};
    send_packet(11'd6, 8'd9);
  endtask

  // a first byte cuts a packet short mid-option
  task automatic test_restart();
    pkt_q = '{8'd7, 8'd2};
    send_packet(11'd20, 8'd9);
    pkt_q = '{8'd7, 8'd1};
    send_packet(11'd4, 8'd7);
  endtask

  // receiver holds off while one-byte packets keep coming, filling the block
  task automatic test_backpressure();
    int i;
    gaps_on = 1'b0;
    hold_req = 1'b1;
    for (i = 0; i < 8; i++) begin
      if (i[0]) send_byte(CODE_END, 1'b1, 11'd4, 8'd9);
      else send_byte(8'h33, 1'b1, 11'd0, 8'd9);
    end
  endtask

  // random packets with idling switched on and off per packet
  task automatic test_random_packets(input int upto);
    while (sent_bytes < upto) begin
      gaps_on  = ($urandom_range(0, 3) != 0);
      stall_on = ($urandom_range(0, 3) != 0);
      random_packet();
    end
  endtask

  // closing stretch at full rate on both sides
  task automatic test_quiet_tail(input int upto);
    gaps_on  = 1'b0;
    stall_on = 1'b0;
    while (sent_bytes < upto) random_packet();
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    gaps_on  = 1'b1;
    stall_on = 1'b1;

    test_idle_bytes();
    test_field_extremes();
    test_area_edges();
    test_pad_end_search();
    test_overload_zero_len();
    test_restart();
    test_backpressure();
    test_random_packets(720);
    test_quiet_tail(820);

    data_valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d packets, %0d bytes sent, %0d parsed, found/absent/malformed %0d/%0d/%0d",
             packets_started, sent_bytes, live_bytes, n_found, n_absent, n_malformed);
    $display("finds in file %0d, in sname %0d; %0d long hold-offs, %0d input stall cycles",
             found_in_file, found_in_sname, long_holds, in_stall_cycles);
    if (mismatches == 0) begin
      $display("dhcp_option_finder_unit verification clean");
    end else begin
      $display("dhcp_option_finder_unit verification failed");
    end
    $finish;
  end

endmodule
